/* hw/rtl/lpe_pkg.sv */
// lpe_pkg: shared types, widths and coefficient tables of the legendre evaluator
`timescale 1ns / 1ps
`default_nettype none

package lpe_pkg;

  // fixed field and datapath widths
  localparam int ORDER_W      = 4;
  localparam int X_W          = 16;
  localparam int XM_W         = 16;
  localparam int S_W          = 31;
  localparam int ACC_FRAC     = 30;
  localparam int ACC_W        = 54;
  localparam int MAG_W        = ACC_W - 1;
  localparam int COEF_W       = 22;
  localparam int SH_W         = 6;
  localparam int TABLE_ORDERS = 13;
  localparam int MAX_TERMS    = 7;
  localparam int TABLE_MAX    = TABLE_ORDERS - 1;

  // coefficients of each order, highest power of x squared first
  localparam logic signed [COEF_W-1:0] COEF_TAB [TABLE_ORDERS][MAX_TERMS] = '{
    '{22'sd1,      22'sd0,        22'sd0,       22'sd0,        22'sd0,      22'sd0,      22'sd0},
    '{22'sd1,      22'sd0,        22'sd0,       22'sd0,        22'sd0,      22'sd0,      22'sd0},
    '{22'sd3,      -22'sd1,       22'sd0,       22'sd0,        22'sd0,      22'sd0,      22'sd0},
    '{22'sd5,      -22'sd3,       22'sd0,       22'sd0,        22'sd0,      22'sd0,      22'sd0},
    '{22'sd35,     -22'sd30,      22'sd3,       22'sd0,        22'sd0,      22'sd0,      22'sd0},
    '{22'sd63,     -22'sd70,      22'sd15,      22'sd0,        22'sd0,      22'sd0,      22'sd0},
    '{22'sd231,    -22'sd315,     22'sd105,     -22'sd5,       22'sd0,      22'sd0,      22'sd0},
    '{22'sd429,    -22'sd693,     22'sd315,     -22'sd35,      22'sd0,      22'sd0,      22'sd0},
    '{22'sd6435,   -22'sd12012,   22'sd6930,    -22'sd1260,    22'sd35,     22'sd0,      22'sd0},
    '{22'sd12155,  -22'sd25740,   22'sd18018,   -22'sd4620,    22'sd315,    22'sd0,      22'sd0},
    '{22'sd46189,  -22'sd109395,  22'sd90090,   -22'sd30030,   22'sd3465,   -22'sd63,    22'sd0},
    '{22'sd88179,  -22'sd230945,  22'sd218790,  -22'sd90090,   22'sd15015,  -22'sd693,   22'sd0},
    '{22'sd676039, -22'sd1939938, 22'sd2078505, -22'sd1021020, 22'sd225225, -22'sd18018, 22'sd231}
  };

  // power of two that divides each order's coefficient form
  localparam logic [3:0] DIV_SHIFT_TAB [TABLE_ORDERS] = '{
    4'd0, 4'd0, 4'd1, 4'd1, 4'd3, 4'd3, 4'd4, 4'd4, 4'd7, 4'd7, 4'd8, 4'd8, 4'd10
  };

  // one item on its way through the pipeline
  typedef struct packed {
    logic [ORDER_W-1:0]      order;
    logic                    bad;
    logic                    xneg;
    logic [XM_W-1:0]         xm;
    logic [S_W-1:0]          s;
    logic signed [ACC_W-1:0] acc;
  } lpe_item_t;

  // one finished result
  typedef struct packed {
    logic [X_W-1:0] poly;
    logic           bad;
  } lpe_result_t;

  // coefficient for the horner step that has `left` steps after it,
  // zero where the order has fewer terms than the pipeline has steps
  function automatic logic signed [COEF_W-1:0] coef_pad(input logic [ORDER_W-1:0] n,
                                                        input logic [2:0] left);
    logic [2:0] half;
    logic [2:0] j;
    logic signed [COEF_W-1:0] c;
    begin
      half = n[ORDER_W-1:1];
      j    = half - left;
      if (n > ORDER_W'(TABLE_MAX) || half < left) begin
        c = '0;
      end else begin
        c = COEF_TAB[n][j];
      end
      return c;
    end
  endfunction

  // divide shift of an order, zero outside the table
  function automatic logic [3:0] div_shift(input logic [ORDER_W-1:0] n);
    logic [3:0] d;
    begin
      if (n > ORDER_W'(TABLE_MAX)) begin
        d = '0;
      end else begin
        d = DIV_SHIFT_TAB[n];
      end
      return d;
    end
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/legendre_polynomial_eval_top.sv */
// legendre_polynomial_eval_top: pipelined legendre polynomial evaluator, orders 0 to 12
//
// Each request carries an order n and an argument x (signed, FRAC_BITS fraction bits) and
// gives one result P_n(x), rounded to nearest and saturated to 16 bits; orders above
// MAX_ORDER give zero with the bad_order flag set. The pipeline takes one request every
// clock cycle while its output queue is not full. A result passes two front stages for
// the square, four stages for each horner step in x squared (magnitude, split multiply,
// sum, coefficient add), five finishing stages and the output queue. The whole pipeline
// holds while its two-entry output queue is full, so requests keep flowing while at most
// one result waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

module legendre_polynomial_eval_top #(
  parameter int MAX_ORDER = 12,
  parameter int FRAC_BITS = 15
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [23:0] s_axis_tdata,   // order[3:0], arg_x[19:4], zero[23:20]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata,   // poly_value[15:0]
  output logic        m_axis_tuser    // bad_order[0]
);
  import lpe_pkg::*;

  localparam int NSTEP = MAX_ORDER / 2;

  logic        en;
  logic        buf_full;
  lpe_item_t   chain_item  [NSTEP+1];
  logic        chain_valid [NSTEP+1];
  logic        fin_valid;
  lpe_result_t fin_res;
  lpe_result_t head_res;

  // the pipeline advances unless the output queue is full
  assign en            = ~buf_full;
  assign s_axis_tready = en;

  // order check, square and start value
  lpe_front #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_ORDER (MAX_ORDER)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .order     (s_axis_tdata[ORDER_W-1:0]),
    .arg_x     (s_axis_tdata[ORDER_W+X_W-1:ORDER_W]),
    .out_valid (chain_valid[0]),
    .out_item  (chain_item[0])
  );

  // horner steps, the last one adds the constant term
  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    lpe_horner_step #(
      .STEPS_LEFT (NSTEP - 1 - i)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (chain_valid[i]),
      .in_item   (chain_item[i]),
      .out_valid (chain_valid[i+1]),
      .out_item  (chain_item[i+1])
    );
  end

  // odd factor, rounding and saturation
  lpe_finish #(
    .FRAC_BITS (FRAC_BITS)
  ) u_finish (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (chain_valid[NSTEP]),
    .in_item   (chain_item[NSTEP]),
    .out_valid (fin_valid),
    .out_res   (fin_res)
  );

  // output queue
  lpe_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (fin_valid && en),
    .push_res  (fin_res),
    .full      (buf_full),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (head_res)
  );

  assign m_axis_tdata = head_res.poly;
  assign m_axis_tuser = head_res.bad;

endmodule

`default_nettype wire

/* hw/rtl/lpe_front.sv */
// lpe_front: order check, argument clamp and magnitude, square and horner start value
`timescale 1ns / 1ps
`default_nettype none

module lpe_front #(
  parameter int FRAC_BITS = 15,
  parameter int MAX_ORDER = 12
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          en,
  input  wire                          in_valid,
  input  wire  [lpe_pkg::ORDER_W-1:0]  order,
  input  wire  [lpe_pkg::X_W-1:0]      arg_x,
  output logic                         out_valid,
  output lpe_pkg::lpe_item_t           out_item
);
  import lpe_pkg::*;

  localparam int NSTEP  = MAX_ORDER / 2;
  localparam int LIM_I  = (FRAC_BITS < 15) ? (1 << FRAC_BITS) : 32768;
  localparam int SQ_SHL = (2 * FRAC_BITS <= ACC_FRAC) ? (ACC_FRAC - 2 * FRAC_BITS) : 0;
  localparam int SQ_SHR = (2 * FRAC_BITS <= ACC_FRAC) ? 0 : (2 * FRAC_BITS - ACC_FRAC);

  lpe_item_t         f1_item;
  lpe_item_t         f1_next;
  lpe_item_t         out_next;
  logic              f1_valid;
  logic [X_W:0]      xs_ext;
  logic [X_W:0]      xmag;
  logic [X_W:0]      xclamp;
  logic [2*XM_W-1:0] sq;
  logic [63:0]       sq_scaled;
  logic signed [COEF_W-1:0] c_top;

  // magnitude of x, clamped to one when the format has fewer than 15 fraction bits
  always_comb begin
    xs_ext = {arg_x[X_W-1], arg_x};
    xmag   = arg_x[X_W-1] ? (~xs_ext + 1'b1) : xs_ext;
    xclamp = (xmag > 17'(LIM_I)) ? 17'(LIM_I) : xmag;
    f1_next       = '0;
    f1_next.order = order;
    f1_next.bad   = (order > ORDER_W'(MAX_ORDER));
    f1_next.xneg  = arg_x[X_W-1];
    f1_next.xm    = xclamp[XM_W-1:0];
  end

  // stage one: check and magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_item <= f1_next;
    end
  end

  // square in 30 fraction bits and the leading coefficient
  always_comb begin
    sq           = f1_item.xm * f1_item.xm;
    sq_scaled    = (64'(sq) << SQ_SHL) >> SQ_SHR;
    c_top        = coef_pad(f1_item.order, 3'(NSTEP));
    out_next     = f1_item;
    out_next.s   = sq_scaled[S_W-1:0];
    out_next.acc = {{(ACC_W - COEF_W - ACC_FRAC){c_top[COEF_W-1]}}, c_top,
                    {ACC_FRAC{1'b0}}};
  end

  // stage two: square and start value
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= out_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lpe_horner_step.sv */
// lpe_horner_step: one horner step acc = trunc(acc * s) + c over four register stages
`timescale 1ns / 1ps
`default_nettype none

module lpe_horner_step #(
  parameter int STEPS_LEFT = 0
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 en,
  input  wire                 in_valid,
  input  lpe_pkg::lpe_item_t  in_item,
  output logic                out_valid,
  output lpe_pkg::lpe_item_t  out_item
);
  import lpe_pkg::*;

  localparam int HI_W = MAG_W - ACC_FRAC;

  lpe_item_t               a_item, b_item, c_item;
  lpe_item_t               out_next;
  logic                    a_valid, b_valid, c_valid;
  logic                    a_neg, b_neg, c_neg;
  logic [MAG_W-1:0]        a_mag;
  logic [HI_W+S_W-1:0]     p_hi;
  logic [ACC_FRAC+S_W-1:0] p_lo;
  logic [MAG_W-1:0]        c_r;
  logic signed [ACC_W-1:0] neg_acc;
  logic [ACC_W-1:0]        r_sum;
  logic signed [COEF_W-1:0] coef;
  logic signed [ACC_W-1:0] cterm;
  logic signed [ACC_W-1:0] r_ext;

  // valid bits move with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      out_valid <= c_valid;
    end
  end

  // sign and magnitude of the accumulator
  assign neg_acc = -in_item.acc;

  always_ff @(posedge clk) begin
    if (en) begin
      a_item <= in_item;
      a_neg  <= in_item.acc[ACC_W-1];
      a_mag  <= in_item.acc[ACC_W-1] ? neg_acc[MAG_W-1:0] : in_item.acc[MAG_W-1:0];
    end
  end

  // partial products of magnitude times s, split at the binary point
  always_ff @(posedge clk) begin
    if (en) begin
      b_item <= a_item;
      b_neg  <= a_neg;
      p_hi   <= a_mag[MAG_W-1:ACC_FRAC] * a_item.s;
      p_lo   <= a_mag[ACC_FRAC-1:0] * a_item.s;
    end
  end

  // truncated product magnitude
  assign r_sum = ACC_W'(p_hi) + ACC_W'(p_lo[ACC_FRAC+S_W-1:ACC_FRAC]);

  always_ff @(posedge clk) begin
    if (en) begin
      c_item <= b_item;
      c_neg  <= b_neg;
      c_r    <= r_sum[MAG_W-1:0];
    end
  end

  // restore the sign and add this step's coefficient
  always_comb begin
    coef         = coef_pad(c_item.order, 3'(STEPS_LEFT));
    cterm        = {{(ACC_W - COEF_W - ACC_FRAC){coef[COEF_W-1]}}, coef, {ACC_FRAC{1'b0}}};
    r_ext        = {1'b0, c_r};
    out_next     = c_item;
    out_next.acc = c_neg ? (cterm - r_ext) : (cterm + r_ext);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= out_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lpe_finish.sv */
// lpe_finish: odd-order x factor, scaling with rounding and saturation to q1.15 at the default FRAC_BITS
`timescale 1ns / 1ps
`default_nettype none

module lpe_finish #(
  parameter int FRAC_BITS = 15
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 en,
  input  wire                 in_valid,
  input  lpe_pkg::lpe_item_t  in_item,
  output logic                out_valid,
  output lpe_pkg::lpe_result_t out_res
);
  import lpe_pkg::*;

  localparam int HI_W   = MAG_W - FRAC_BITS;
  localparam int PROD_W = MAG_W + XM_W;

  logic                    v1, v2, v3, v4;
  lpe_item_t               i1, i2;
  logic                    n1, n2, n3, n4;
  logic                    b3, b4;
  logic [MAG_W-1:0]        m1, m2, m3;
  logic [HI_W+XM_W-1:0]    ph;
  logic [FRAC_BITS+XM_W-1:0] pl;
  logic [ACC_W-1:0]        mr;
  logic [SH_W-1:0]         sh3, sh4;
  logic signed [ACC_W-1:0] neg_acc;
  logic [PROD_W-1:0]       odd_sum;
  logic [ACC_W-1:0]        half;
  logic [ACC_W-1:0]        q;
  logic                    big;
  logic [X_W-1:0]          poly;

  // valid bits move with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  // sign and magnitude of the horner result
  assign neg_acc = -in_item.acc;

  always_ff @(posedge clk) begin
    if (en) begin
      i1 <= in_item;
      n1 <= in_item.acc[ACC_W-1];
      m1 <= in_item.acc[ACC_W-1] ? neg_acc[MAG_W-1:0] : in_item.acc[MAG_W-1:0];
    end
  end

  // partial products of magnitude times |x|, split at the binary point of x
  always_ff @(posedge clk) begin
    if (en) begin
      i2 <= i1;
      n2 <= n1;
      m2 <= m1;
      ph <= m1[MAG_W-1:FRAC_BITS] * i1.xm;
      pl <= m1[FRAC_BITS-1:0] * i1.xm;
    end
  end

  // odd orders take the factor x, even orders pass straight on
  assign odd_sum = PROD_W'(ph) + PROD_W'(pl[FRAC_BITS+XM_W-1:FRAC_BITS]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (i2.order[0]) begin
        m3 <= odd_sum[MAG_W-1:0];
        n3 <= n2 ^ i2.xneg;
      end else begin
        m3 <= m2;
        n3 <= n2;
      end
      b3  <= i2.bad;
      sh3 <= SH_W'(div_shift(i2.order)) + SH_W'(ACC_FRAC - FRAC_BITS);
    end
  end

  // add half an output lsb for round to nearest, ties away from zero
  assign half = (sh3 == '0) ? '0 : (ACC_W'(1) << (sh3 - 1'b1));

  always_ff @(posedge clk) begin
    if (en) begin
      mr  <= ACC_W'(m3) + half;
      sh4 <= sh3;
      n4  <= n3;
      b4  <= b3;
    end
  end

  // scale down, saturate and apply the sign
  always_comb begin
    q   = mr >> sh4;
    big = |q[ACC_W-1:X_W-1];
    if (b4) begin
      poly = '0;
    end else if (big) begin
      poly = n4 ? {1'b1, {(X_W-1){1'b0}}} : {1'b0, {(X_W-1){1'b1}}};
    end else if (n4) begin
      poly = ~q[X_W-1:0] + 1'b1;
    end else begin
      poly = q[X_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res <= '{poly: poly, bad: b4};
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lpe_out_buf.sv */
// lpe_out_buf: two-entry output queue that parts the pipeline from the result channel
`timescale 1ns / 1ps
`default_nettype none

module lpe_out_buf (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  lpe_pkg::lpe_result_t push_res,
  output logic                 full,
  output logic                 out_valid,
  input  wire                  out_ready,
  output lpe_pkg::lpe_result_t out_res
);
  import lpe_pkg::*;

  lpe_result_t entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_res   = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_res;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lpe_checker.sv */
// lpe_checker: port-level assertions on the legendre evaluator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module lpe_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [15:0] m_axis_tdata,
  input wire        m_axis_tuser
);

  logic [7:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // requests taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 8'd0;
    end else begin
      pending <= pending + 8'(in_acc) - 8'(out_acc);
    end
  end

  // a bad order always comes back as zero
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'd0)
    else $error("bad order result with nonzero value");

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // no result without an outstanding request
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pending != 8'd0)
    else $error("result without a request");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result present after reset");

  // input only stalls while results wait to be taken
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

endmodule

bind legendre_polynomial_eval_top lpe_checker u_lpe_checker (.*);

`default_nettype wire
